// ===== rtl/lrct_pkg.sv =====
package lrct_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int CNT_W = 14;
    localparam int BLINK_W = 8;
    localparam int CODE_W = 16;
    localparam int SLOT_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_WINDOW = 3'd0,
        REG_CLEAR_PRESS  = 3'd1,
        REG_LEARN_PRESS  = 3'd2,
        REG_BLINK_PERIOD = 3'd3,
        REG_COUNT_LIMIT  = 3'd4
    } t_reg_idx;

    localparam logic [CNT_W-1:0]   RST_START_WINDOW = 14'd300;
    localparam logic [CNT_W-1:0]   RST_CLEAR_PRESS  = 14'd50;
    localparam logic [CNT_W-1:0]   RST_LEARN_PRESS  = 14'd100;
    localparam logic [BLINK_W-1:0] RST_BLINK_PERIOD = 8'd10;
    localparam logic [CNT_W-1:0]   RST_COUNT_LIMIT  = 14'd10000;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CODE = 1'b1;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/lrct_ctrl.sv =====
module lrct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output lrct_pkg::t_cmd o_cmd
);
    import lrct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_WORK;
                end
            end
            S_WORK: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/lrct_dp.sv =====
module lrct_dp #(
    parameter int SLOTS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lrct_pkg::t_cmd                 i_cmd,
    input  logic                           i_cfg_we,
    input  logic [lrct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_op,
    input  logic                           i_button,
    input  logic [7:0]                     i_code_high,
    input  logic [7:0]                     i_code_low,
    output logic                           o_activate,
    output logic                           o_learn_mode,
    output logic                           o_led_blink,
    output logic                           o_stored,
    output logic                           o_already_known,
    output logic                           o_table_full,
    output logic                           o_cleared,
    output logic                           o_save_request,
    output logic [lrct_pkg::SLOT_W-1:0]    o_slot
);
    import lrct_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [CNT_W-1:0]   r_start_window, r_clear_press, r_learn_press, r_count_limit;
    logic [BLINK_W-1:0] r_blink_period;

    logic               r_op, r_button;
    logic [CODE_W-1:0]  r_code;

    logic [CODE_W-1:0]  r_slots [SLOTS];
    logic [CODE_W-1:0]  n_slots [SLOTS];
    logic [CNT_W-1:0]   r_uptime, n_uptime, r_hold, n_hold;
    logic               r_learn, n_learn, r_blink, n_blink;
    logic [BLINK_W-1:0] r_bcnt, n_bcnt, per;

    logic [CNT_W-1:0]   up_inc, hold_inc;
    logic               hit, empty_hit;
    logic [SW-1:0]      hit_idx, empty_idx;

    logic res_act, res_stored, res_known, res_full, res_clr, res_save;
    logic [SLOT_W-1:0] res_slot;

    always_comb begin
        hit       = 1'b0;
        hit_idx   = '0;
        empty_hit = 1'b0;
        empty_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_slots[i] == r_code) begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
            if (r_slots[i] == '0) begin
                empty_hit = 1'b1;
                empty_idx = SW'(i);
            end
        end
    end

    assign per = (r_blink_period == '0) ? BLINK_W'(1) : r_blink_period;

    always_comb begin
        n_slots    = r_slots;
        n_uptime   = r_uptime;
        n_hold     = r_hold;
        n_learn    = r_learn;
        n_blink    = r_blink;
        n_bcnt     = r_bcnt;
        up_inc     = r_uptime;
        hold_inc   = '0;
        res_act    = 1'b0;
        res_stored = 1'b0;
        res_known  = 1'b0;
        res_full   = 1'b0;
        res_clr    = 1'b0;
        res_save   = 1'b0;
        res_slot   = '0;
        if (r_op == OP_TICK) begin
            if (!r_learn) begin
                up_inc   = (r_uptime < r_count_limit) ? r_uptime + CNT_W'(1) : r_uptime;
                hold_inc = (r_button && r_hold < r_count_limit) ? r_hold + CNT_W'(1) : '0;
                n_uptime = up_inc;
                n_hold   = hold_inc;
                if (up_inc < r_start_window && hold_inc > r_clear_press) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        n_slots[i] = '0;
                    end
                    n_uptime = r_count_limit;
                    n_hold   = '0;
                    res_clr  = 1'b1;
                    res_save = 1'b1;
                end
                if (n_hold >= r_learn_press) begin
                    n_learn = 1'b1;
                    n_bcnt  = '0;
                end
            end else begin
                n_bcnt = r_bcnt + BLINK_W'(1);
                if (n_bcnt >= per) begin
                    n_blink = !r_blink;
                    n_bcnt  = '0;
                end
            end
        end else begin
            if (!r_learn) begin
                if (hit) begin
                    res_act  = 1'b1;
                    res_slot = SLOT_W'(hit_idx);
                end
            end else begin
                if (hit) begin
                    res_known = 1'b1;
                    res_slot  = SLOT_W'(hit_idx);
                end else begin
                    if (empty_hit) begin
                        n_slots[empty_idx] = r_code;
                        res_stored         = 1'b1;
                        res_slot           = SLOT_W'(empty_idx);
                    end else begin
                        res_full = 1'b1;
                    end
                    res_save = 1'b1;
                end
                n_learn = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_window <= RST_START_WINDOW;
            r_clear_press  <= RST_CLEAR_PRESS;
            r_learn_press  <= RST_LEARN_PRESS;
            r_blink_period <= RST_BLINK_PERIOD;
            r_count_limit  <= RST_COUNT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_WINDOW: r_start_window <= i_cfg_data;
                REG_CLEAR_PRESS:  r_clear_press  <= i_cfg_data;
                REG_LEARN_PRESS:  r_learn_press  <= i_cfg_data;
                REG_BLINK_PERIOD: r_blink_period <= i_cfg_data[BLINK_W-1:0];
                REG_COUNT_LIMIT:  r_count_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slots[i] <= '0;
            end
            r_uptime <= '0;
            r_hold   <= '0;
            r_learn  <= 1'b0;
            r_blink  <= 1'b0;
            r_bcnt   <= '0;
        end else if (i_cmd.exec) begin
            r_slots  <= n_slots;
            r_uptime <= n_uptime;
            r_hold   <= n_hold;
            r_learn  <= n_learn;
            r_blink  <= n_blink;
            r_bcnt   <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_button <= i_button;
            r_code   <= {i_code_high, i_code_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_activate      <= res_act;
            o_learn_mode    <= n_learn;
            o_led_blink     <= n_learn && n_blink;
            o_stored        <= res_stored;
            o_already_known <= res_known;
            o_table_full    <= res_full;
            o_cleared       <= res_clr;
            o_save_request  <= res_save;
            o_slot          <= res_slot;
        end
    end

endmodule

// ===== rtl/learning_remote_code_table.sv =====
// Each input beat is captured, then executed into the registered result beat.
// The controller holds one item from capture to execute and stalls new input until that execute.
// Execute waits while a previous result beat is still stalled in the output register.
// Reset (i_rst_n low, synchronous): table and counters cleared, config registers to defaults.
module learning_remote_code_table #(
    parameter int SLOTS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic                            i_button,
    input  logic [7:0]                      i_code_high,
    input  logic [7:0]                      i_code_low,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_activate,
    output logic                            o_learn_mode,
    output logic                            o_led_blink,
    output logic                            o_stored,
    output logic                            o_already_known,
    output logic                            o_table_full,
    output logic                            o_cleared,
    output logic                            o_save_request,
    output logic [lrct_pkg::SLOT_W-1:0]     o_slot
);
    import lrct_pkg::*;

    t_cmd cmd;

    lrct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lrct_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_button        (i_button),
        .i_code_high     (i_code_high),
        .i_code_low      (i_code_low),
        .o_activate      (o_activate),
        .o_learn_mode    (o_learn_mode),
        .o_led_blink     (o_led_blink),
        .o_stored        (o_stored),
        .o_already_known (o_already_known),
        .o_table_full    (o_table_full),
        .o_cleared       (o_cleared),
        .o_save_request  (o_save_request),
        .o_slot          (o_slot)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while controller not busy next cycle");

    a_stored_leaves_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_stored || o_table_full || o_already_known)) |-> !o_learn_mode)
        else $error("learn result while still in learn mode");

    a_clear_saves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cleared) |-> o_save_request)
        else $error("table clear without save request");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ($countones({o_activate, o_stored, o_already_known, o_table_full}) <= 1))
        else $error("more than one code outcome in a beat");

endmodule
